// ----- hdl/prdd_pkg.sv -----
// Shared types, widths and helpers for the permutation rank unit.
package prdd_pkg;

    localparam int DIGITS = 5;
    localparam int WORD_W = 17;
    localparam int RANK_W = 7;
    localparam int CNT_W = $clog2(DIGITS);
    localparam int S_TDATA_W = ((WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RANK_W + 7) / 8) * 8;
    localparam int STAGES = DIGITS + 2;

    localparam int DIV10_MUL = 104858;
    localparam int DIV10_SHIFT = 20;
    localparam int PROD_W = WORD_W + 17;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [3:0] digit_t;
    typedef digit_t [DIGITS-1:0] digits_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef cnt_t [DIGITS-2:0] counts_t;

    function automatic word_t div10(input word_t v);
        logic [PROD_W-1:0] prod;
        begin
            prod = PROD_W'(v) * PROD_W'(DIV10_MUL);
            div10 = WORD_W'(prod >> DIV10_SHIFT);
        end
    endfunction

    function automatic rank_t fact_mod(input int n);
        rank_t f;
        begin
            f = RANK_W'(1);
            for (int k = 2; k <= n; k++)
            begin
                f = RANK_W'(f * RANK_W'(k));
            end
            fact_mod = f;
        end
    endfunction

endpackage

// ----- hdl/prdd_split.sv -----
// Digit extraction pipeline: one decimal digit per stage, least significant first.
module prdd_split
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  prdd_pkg::word_t   up_word,
    output logic              dn_valid,
    input  logic              dn_ready,
    output prdd_pkg::digits_t dn_digits
);

    localparam int N = prdd_pkg::DIGITS;

    logic [N-1:0]            vld_reg;
    prdd_pkg::word_t         val_reg [N];
    prdd_pkg::digits_t       dig_reg [N];
    logic [N:0]              adv;

    assign adv[N] = dn_ready;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            logic              src_valid;
            prdd_pkg::word_t   src_val;
            prdd_pkg::digits_t src_dig;
            prdd_pkg::word_t   quot;
            prdd_pkg::word_t   rem_full;
            prdd_pkg::word_t   val_next;
            prdd_pkg::digits_t dig_next;

            if (s == 0)
            begin : g_first
                assign src_valid = up_valid;
                assign src_val   = up_word;
                assign src_dig   = '0;
            end
            else
            begin : g_rest
                assign src_valid = vld_reg[s-1];
                assign src_val   = val_reg[s-1];
                assign src_dig   = dig_reg[s-1];
            end

            assign adv[s] = !vld_reg[s] || adv[s+1];

            always_comb
            begin
                quot     = prdd_pkg::div10(src_val);
                rem_full = src_val - prdd_pkg::word_t'((quot << 3) + (quot << 1));
                val_next = quot;
                dig_next = src_dig;
                dig_next[N-1-s] = rem_full[3:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (adv[s])
                begin
                    vld_reg[s] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s] && src_valid)
                begin
                    val_reg[s] <= val_next;
                    dig_reg[s] <= dig_next;
                end
            end
        end
    endgenerate

    assign up_ready  = adv[0];
    assign dn_valid  = vld_reg[N-1];
    assign dn_digits = dig_reg[N-1];

endmodule

// ----- hdl/prdd_rank.sv -----
// Rank pipeline: smaller-later counts, then factorial-weighted sum plus one.
module prdd_rank
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  prdd_pkg::digits_t up_digits,
    output logic              dn_valid,
    input  logic              dn_ready,
    output prdd_pkg::rank_t   dn_rank
);

    localparam int N = prdd_pkg::DIGITS;

    logic              cnt_vld_reg;
    prdd_pkg::counts_t cnt_reg;
    prdd_pkg::counts_t cnt_next;
    logic              rank_vld_reg;
    prdd_pkg::rank_t   rank_reg;
    prdd_pkg::rank_t   rank_next;
    logic              adv_cnt;
    logic              adv_rank;

    assign adv_rank = !rank_vld_reg || dn_ready;
    assign adv_cnt  = !cnt_vld_reg || adv_rank;

    always_comb
    begin
        for (int i = 0; i < N - 1; i++)
        begin
            cnt_next[i] = '0;
            for (int j = i + 1; j < N; j++)
            begin
                cnt_next[i] = prdd_pkg::CNT_W'(cnt_next[i]
                              + prdd_pkg::CNT_W'(up_digits[i] > up_digits[j]));
            end
        end
    end

    always_comb
    begin
        rank_next = prdd_pkg::RANK_W'(1);
        for (int i = 0; i < N - 1; i++)
        begin
            rank_next = prdd_pkg::RANK_W'(rank_next
                        + prdd_pkg::RANK_W'(prdd_pkg::RANK_W'(cnt_reg[i])
                                            * prdd_pkg::fact_mod(N - 1 - i)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg  <= 1'b0;
            rank_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv_cnt)
            begin
                cnt_vld_reg <= up_valid;
            end
            if (adv_rank)
            begin
                rank_vld_reg <= cnt_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_cnt && up_valid)
        begin
            cnt_reg <= cnt_next;
        end
        if (adv_rank && cnt_vld_reg)
        begin
            rank_reg <= rank_next;
        end
    end

    assign up_ready = adv_cnt;
    assign dn_valid = rank_vld_reg;
    assign dn_rank  = rank_reg;

endmodule

// ----- hdl/permutation_rank_of_decimal_digits_unit.sv -----
// Throughput: one item per cycle while the output is not stalled; one decimal digit
// split off per stage, then a count stage and a weighted-sum stage, each stage
// with its own valid bit.
// Stages stall independently, so bubbles fill while the output waits.
// Reset (rst_n low, asynchronous) empties every stage; no other state.
module permutation_rank_of_decimal_digits_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [prdd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [16:0] digit_word, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [prdd_pkg::M_TDATA_W-1:0] m_axis_tdata   // [6:0] rank, rest zero
);

    logic              mid_valid;
    logic              mid_ready;
    prdd_pkg::digits_t mid_digits;
    prdd_pkg::rank_t   rank;

    prdd_split u_split
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s_axis_tvalid),
        .up_ready  (s_axis_tready),
        .up_word   (s_axis_tdata[prdd_pkg::WORD_W-1:0]),
        .dn_valid  (mid_valid),
        .dn_ready  (mid_ready),
        .dn_digits (mid_digits)
    );

    prdd_rank u_rank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (mid_valid),
        .up_ready  (mid_ready),
        .up_digits (mid_digits),
        .dn_valid  (m_axis_tvalid),
        .dn_ready  (m_axis_tready),
        .dn_rank   (rank)
    );

    assign m_axis_tdata = prdd_pkg::M_TDATA_W'(rank);

endmodule

// ----- dv/prdd_rank_checker.sv -----
// Checker for the permutation rank unit: predicts each rank and compares results in order.
`timescale 1ns / 1ps

module prdd_rank_checker
    import prdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [16:0] digit_word, rest zero
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,   // [6:0] rank, rest zero
    output int                   fail_count,
    output int                   waiting,
    output int                   results_seen
);

    typedef struct packed
    {
        word_t word;
        rank_t rank;
    } rank_expect_t;

    rank_expect_t rank_expect_q[$];
    rank_expect_t head;
    logic [M_TDATA_W-1:0] want;
    int fails;
    int seen;

    function automatic rank_t cantor_rank(input word_t w);
        int unsigned v;
        int unsigned total;
        int unsigned weight;
        int unsigned smaller;
        digit_t dig [DIGITS];
        begin
            v = 32'(w);
            for (int p = DIGITS - 1; p >= 0; p--)
            begin
                dig[p] = digit_t'(v % 10);
                v = v / 10;
            end
            total = 0;
            weight = 1;
            for (int p = DIGITS - 2; p >= 0; p--)
            begin
                weight = weight * (DIGITS - 1 - p);
                smaller = 0;
                for (int q = p + 1; q < DIGITS; q++)
                begin
                    if (dig[p] > dig[q])
                    begin
                        smaller++;
                    end
                end
                total += smaller * weight;
            end
            return rank_t'(total + 1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_expect_q.delete();
            fails = 0;
            seen = 0;
            fail_count <= 0;
            waiting <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                head.word = word_t'(s_axis_tdata);
                head.rank = cantor_rank(head.word);
                rank_expect_q.push_back(head);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen++;
                if (rank_expect_q.size() == 0)
                begin
                    if (fails < 10)
                    begin
                        $display("%0t: unexpected result item, tdata 0x%0h", $time, m_axis_tdata);
                    end
                    fails++;
                end
                else
                begin
                    head = rank_expect_q.pop_front();
                    want = M_TDATA_W'(head.rank);
                    if (m_axis_tdata !== want)
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: word %0d rank expected %0d (tdata 0x%0h), got tdata 0x%0h",
                                     $time, head.word, head.rank, want, m_axis_tdata);
                        end
                        fails++;
                    end
                end
            end
            fail_count <= fails;
            waiting <= rank_expect_q.size();
            results_seen <= seen;
        end
    end

endmodule

// ----- dv/permutation_rank_of_decimal_digits_unit_tb.sv -----
// Testbench top for the permutation rank unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module permutation_rank_of_decimal_digits_unit_tb;

    import prdd_pkg::*;

    localparam int LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;
    localparam longint DEC_SPAN = longint'(10) ** DIGITS;
    localparam longint WORD_SPAN = longint'(1) << WORD_W;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [16:0] digit_word, rest zero
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [6:0] rank, rest zero
    logic                 long_hold;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int waiting;
    int results_seen;
    int words_sent;
    int cycle_count;

    permutation_rank_of_decimal_digits_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    prdd_rank_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .waiting       (waiting),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int held;
        held = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && held < HOLD_CYCLES)
            begin
                m_axis_tready <= 1'b0;
                held++;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic word_t next_word();
        int pool [10];
        int pick;
        int tmp;
        int sel;
        int d;
        longint acc;
        begin
            sel = $urandom_range(99);
            if (sel < 14)
            begin
                return word_t'($urandom_range(int'(WORD_SPAN - 1)));
            end
            if (sel < 22 && DEC_SPAN < WORD_SPAN)
            begin
                return word_t'($urandom_range(int'(WORD_SPAN - 1), int'(DEC_SPAN)));
            end
            for (int k = 0; k < 10; k++)
            begin
                pool[k] = k;
            end
            for (int k = 9; k > 0; k--)
            begin
                pick = $urandom_range(k);
                tmp = pool[k];
                pool[k] = pool[pick];
                pool[pick] = tmp;
            end
            acc = 0;
            for (int k = 0; k < DIGITS; k++)
            begin
                if (sel < 72)
                begin
                    d = pool[k];
                end
                else if (sel < 88)
                begin
                    d = $urandom_range(2);
                end
                else
                begin
                    d = $urandom_range(9);
                end
                acc = acc * 10 + d;
            end
            return word_t'(acc);
        end
    endfunction

    task automatic offer_word(input word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_TDATA_W'(w);
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int n = 0; n < count; n++)
        begin
            offer_word(next_word());
        end
    endtask

    initial
    begin
        int edge_words [$];
        int drain;
        edge_words = '{0, 99999, 12345, 54321, 1234, 43210, 98765, 56789, 21435, 13254,
                       11111, 10001, 90000, 55555, 12321, 100000, 131071, 65536, 99999 + 12,
                       1, 10, 9, 45312, 24153};
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        long_hold <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        words_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_words[k])
        begin
            offer_word(word_t'(edge_words[k]));
        end

        run_phase(250, 0, 0);
        run_phase(250, 65, 0);
        run_phase(250, 0, 65);
        run_phase(250, 14, 14);
        long_hold <= 1'b1;
        run_phase(250, 0, 0);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (waiting != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (STAGES + 8) @(posedge clk);

        $display("Sent %0d digit words (edge values, permutations, repeats, out-of-range words)",
                 words_sent);
        $display("Checked %0d ranks across five idle patterns and a %0d-cycle output hold",
                 results_seen, HOLD_CYCLES);
        if (fail_count == 0 && waiting == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", fail_count, waiting);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/prdd_pkg.sv
hdl/prdd_split.sv
hdl/prdd_rank.sv
hdl/permutation_rank_of_decimal_digits_unit.sv
dv/prdd_rank_checker.sv
dv/permutation_rank_of_decimal_digits_unit_tb.sv
